>>> design/ddet_pkg.sv
// Shared types and constants for the deadlock detector.
// No dependencies; compiled before every other design file.
`default_nettype none

package ddet_pkg;

   localparam int DEF_MAX_PROCESSES = 16;
   localparam int DEF_MAX_RESOURCES = 8;
   localparam int DEF_COUNT_BITS    = 16;

   localparam int PROC_INDEX_WIDTH = 4;
   localparam int RES_INDEX_WIDTH  = 3;
   localparam int VALUE_WIDTH      = 16;
   localparam int MASK_WIDTH       = 16;
   localparam int COUNT_OUT_WIDTH  = 5;

   localparam int RES_CFG_WIDTH   = 4;
   localparam int PROC_CFG_WIDTH  = 5;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 5;

   typedef enum logic [1:0] {
      MODE_WRITE_AVAIL = 2'd0,
      MODE_WRITE_ALLOC = 2'd1,
      MODE_WRITE_REQ   = 2'd2,
      MODE_RUN         = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RESOURCES_IN_USE = 1'd0,
      CSR_PROCESSES_IN_USE = 1'd1
   } csr_index_type;

endpackage

`default_nettype wire

>>> design/ddet_if.sv
// Request and response channel interfaces of the deadlock detector.
// Depends on ddet_pkg for field widths and the mode type.
`default_nettype none

interface ddet_req_if;
   logic                                   valid;
   logic                                   ready;
   ddet_pkg::mode_type                     mode;
   logic [ddet_pkg::PROC_INDEX_WIDTH-1:0]  process_index;
   logic [ddet_pkg::RES_INDEX_WIDTH-1:0]   resource_index;
   logic [ddet_pkg::VALUE_WIDTH-1:0]       value;

   modport source (output valid, output mode, output process_index,
                   output resource_index, output value, input ready);
   modport sink   (input valid, input mode, input process_index,
                   input resource_index, input value, output ready);
endinterface

interface ddet_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  deadlock_found;
   logic [ddet_pkg::MASK_WIDTH-1:0]       deadlocked_mask;
   logic [ddet_pkg::COUNT_OUT_WIDTH-1:0]  deadlocked_count;

   modport source (output valid, output deadlock_found, output deadlocked_mask,
                   output deadlocked_count, input ready);
   modport sink   (input valid, input deadlock_found, input deadlocked_mask,
                   input deadlocked_count, output ready);
endinterface

`default_nettype wire

>>> design/ddet_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ddet_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output      logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data <= mem_ff[read_addr];
   end

endmodule

`default_nettype wire

>>> design/deadlock_detector.sv
// Deadlock detector: a run item copies the available vector into the work
// vector, then per pass over nproc processes skips a finished process, tests
// the others until a request exceeds the work vector and releases a process
// whose test passes; at most nproc + 1 passes, then the unfinished processes
// are counted and the result posted. One shared adder does every copy, compare
// and release. Ready stays low for the whole run. Reset clears the sequencer,
// the progress flag, the work vector, the finished mask and the response valid.
`default_nettype none

module deadlock_detector #(
   parameter int MAX_PROCESSES = ddet_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = ddet_pkg::DEF_MAX_RESOURCES,
   parameter int COUNT_BITS    = ddet_pkg::DEF_COUNT_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ddet_req_if.sink                                 req_ch,
   ddet_rsp_if.source                               rsp_ch,
   input  wire logic                                csr_write_enable,
   input  wire logic [ddet_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ddet_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import ddet_pkg::*;

   localparam int PW     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RW     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int PCW    = $clog2(MAX_PROCESSES + 1);
   localparam int RCW    = $clog2(MAX_RESOURCES + 1);
   localparam int OPW    = (COUNT_BITS > VALUE_WIDTH) ? COUNT_BITS : VALUE_WIDTH;
   localparam int ADDR_W = PW + RW;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [OPW-1:0] WORK_CAP = OPW'((64'd1 << COUNT_BITS) - 64'd1);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_COPY     = 10'b0000000010,
      S_SCAN     = 10'b0000000100,
      S_CHK_WAIT = 10'b0000001000,
      S_CHK_CMP  = 10'b0000010000,
      S_ADD_WAIT = 10'b0000100000,
      S_ADD_SUM  = 10'b0001000000,
      S_NEXT_P   = 10'b0010000000,
      S_COUNT    = 10'b0100000000,
      S_DONE     = 10'b1000000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [RCW-1:0]            r_ff, r_in;
   logic [PCW-1:0]            p_ff, p_in;
   logic                      progress_ff, progress_in;
   logic [MAX_PROCESSES-1:0]  finished_ff, finished_in;
   logic [PCW-1:0]            count_ff, count_in;
   logic [COUNT_BITS-1:0]     work_ff [MAX_RESOURCES];
   logic [COUNT_BITS-1:0]     work_in [MAX_RESOURCES];
   logic [VALUE_WIDTH-1:0]    avail_ff [MAX_RESOURCES];
   logic [VALUE_WIDTH-1:0]    avail_in [MAX_RESOURCES];
   logic [RES_CFG_WIDTH-1:0]  res_cfg_ff, res_cfg_in;
   logic [PROC_CFG_WIDTH-1:0] proc_cfg_ff, proc_cfg_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       found_ff, found_in;
   logic [MASK_WIDTH-1:0]      mask_ff, mask_in;
   logic [COUNT_OUT_WIDTH-1:0] dcount_ff, dcount_in;

   logic [RCW-1:0]           nres;
   logic [PCW-1:0]           nproc;
   logic [RW-1:0]            r_idx;
   logic [PW-1:0]            p_idx;
   logic                     last_r;
   logic                     last_p;
   logic                     req_fire;
   logic                     in_range;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic [VALUE_WIDTH-1:0]   alloc_rdata;
   logic [VALUE_WIDTH-1:0]   req_rdata;
   logic [OPW-1:0]           opa;
   logic [OPW-1:0]           opb;
   logic                     cin;
   logic [OPW:0]             sum;
   logic                     fits;
   logic [COUNT_BITS-1:0]    sat_sum;
   logic [MAX_PROCESSES-1:0] dead;

   // register counts, clamped into 1..store size
   always_comb begin
      if (res_cfg_ff == '0) begin
         nres = RCW'(1);
      end else if (int'(res_cfg_ff) > MAX_RESOURCES) begin
         nres = RCW'(MAX_RESOURCES);
      end else begin
         nres = RCW'(res_cfg_ff);
      end
      if (proc_cfg_ff == '0) begin
         nproc = PCW'(1);
      end else if (int'(proc_cfg_ff) > MAX_PROCESSES) begin
         nproc = PCW'(MAX_PROCESSES);
      end else begin
         nproc = PCW'(proc_cfg_ff);
      end
   end

   assign r_idx    = r_ff[RW-1:0];
   assign p_idx    = p_ff[PW-1:0];
   assign last_r   = (r_ff == nres - RCW'(1));
   assign last_p   = (p_ff == nproc - PCW'(1));
   assign req_fire = req_ch.valid && req_ch.ready;
   assign in_range = (int'(req_ch.process_index) < MAX_PROCESSES)
                     && (int'(req_ch.resource_index) < MAX_RESOURCES);
   assign wr_addr  = {PW'(req_ch.process_index), RW'(req_ch.resource_index)};
   assign rd_addr  = {p_idx, r_idx};

   ddet_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_alloc_ram (
      .clock        (clock),
      .write_enable (req_fire && (req_ch.mode == MODE_WRITE_ALLOC) && in_range),
      .write_addr   (wr_addr),
      .write_data   (req_ch.value),
      .read_addr    (rd_addr),
      .read_data    (alloc_rdata)
   );

   ddet_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_req_ram (
      .clock        (clock),
      .write_enable (req_fire && (req_ch.mode == MODE_WRITE_REQ) && in_range),
      .write_addr   (wr_addr),
      .write_data   (req_ch.value),
      .read_addr    (rd_addr),
      .read_data    (req_rdata)
   );

   // shared adder: saturating copy, compare by subtraction, saturating release
   always_comb begin
      opa = (state_ff == S_COPY) ? OPW'(avail_ff[r_idx]) : OPW'(work_ff[r_idx]);
      case (state_ff)
         S_CHK_CMP: opb = ~OPW'(req_rdata);
         S_ADD_SUM: opb = OPW'(alloc_rdata);
         default:   opb = '0;
      endcase
      cin     = (state_ff == S_CHK_CMP);
      sum     = {1'b0, opa} + {1'b0, opb} + (OPW + 1)'(cin);
      fits    = sum[OPW];
      sat_sum = (sum > {1'b0, WORK_CAP}) ? WORK_CAP[COUNT_BITS-1:0]
                                         : sum[COUNT_BITS-1:0];
   end

   always_comb begin
      for (int i = 0; i < MAX_PROCESSES; i++) begin
         dead[i] = !finished_ff[i] && (i < int'(nproc));
      end
   end

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      p_in         = p_ff;
      progress_in  = progress_ff;
      finished_in  = finished_ff;
      count_in     = count_ff;
      work_in      = work_ff;
      avail_in     = avail_ff;
      res_cfg_in   = res_cfg_ff;
      proc_cfg_in  = proc_cfg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      found_in     = found_ff;
      mask_in      = mask_ff;
      dcount_in    = dcount_ff;

      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_RESOURCES_IN_USE: res_cfg_in  = csr_write_data[RES_CFG_WIDTH-1:0];
            CSR_PROCESSES_IN_USE: proc_cfg_in = csr_write_data[PROC_CFG_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_ch.mode)
                  MODE_WRITE_AVAIL: begin
                     if (int'(req_ch.resource_index) < MAX_RESOURCES) begin
                        avail_in[RW'(req_ch.resource_index)] = req_ch.value;
                     end
                  end
                  MODE_RUN: begin
                     r_in        = '0;
                     finished_in = '0;
                     progress_in = 1'b0;
                     state_in    = S_COPY;
                  end
                  default: ;
               endcase
            end
         end
         S_COPY: begin
            work_in[r_idx] = sat_sum;
            if (last_r) begin
               p_in     = '0;
               state_in = S_SCAN;
            end else begin
               r_in = r_ff + RCW'(1);
            end
         end
         S_SCAN: begin
            r_in     = '0;
            state_in = finished_ff[p_idx] ? S_NEXT_P : S_CHK_WAIT;
         end
         S_CHK_WAIT: begin
            state_in = S_CHK_CMP;
         end
         S_CHK_CMP: begin
            if (!fits) begin
               state_in = S_NEXT_P;
            end else if (last_r) begin
               r_in     = '0;
               state_in = S_ADD_WAIT;
            end else begin
               r_in     = r_ff + RCW'(1);
               state_in = S_CHK_WAIT;
            end
         end
         S_ADD_WAIT: begin
            state_in = S_ADD_SUM;
         end
         S_ADD_SUM: begin
            work_in[r_idx] = sat_sum;
            if (last_r) begin
               finished_in[p_idx] = 1'b1;
               progress_in        = 1'b1;
               state_in           = S_NEXT_P;
            end else begin
               r_in     = r_ff + RCW'(1);
               state_in = S_ADD_WAIT;
            end
         end
         S_NEXT_P: begin
            if (!last_p) begin
               p_in     = p_ff + PCW'(1);
               state_in = S_SCAN;
            end else if (progress_ff) begin
               p_in        = '0;
               progress_in = 1'b0;
               state_in    = S_SCAN;
            end else begin
               p_in     = '0;
               count_in = '0;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            if (!finished_ff[p_idx]) begin
               count_in = count_ff + PCW'(1);
            end
            if (last_p) begin
               state_in = S_DONE;
            end else begin
               p_in = p_ff + PCW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               found_in     = (count_ff != '0);
               mask_in      = MASK_WIDTH'(dead);
               dcount_in    = COUNT_OUT_WIDTH'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         progress_ff  <= 1'b0;
         finished_ff  <= '0;
         work_ff      <= '{default: '0};
         res_cfg_ff   <= RES_CFG_WIDTH'(8);
         proc_cfg_ff  <= PROC_CFG_WIDTH'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         progress_ff  <= progress_in;
         finished_ff  <= finished_in;
         work_ff      <= work_in;
         res_cfg_ff   <= res_cfg_in;
         proc_cfg_ff  <= proc_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      p_ff      <= p_in;
      count_ff  <= count_in;
      avail_ff  <= avail_in;
      found_ff  <= found_in;
      mask_ff   <= mask_in;
      dcount_ff <= dcount_in;
   end

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.deadlock_found   = found_ff;
   assign rsp_ch.deadlocked_mask  = mask_ff;
   assign rsp_ch.deadlocked_count = dcount_ff;

endmodule

`default_nettype wire

>>> design/ddet_checker.sv
// Port-level assertions for deadlock_detector and the bind that attaches them.
// Depends on ddet_pkg and on the top level's channel interfaces.
`default_nettype none

module ddet_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire ddet_pkg::mode_type                   req_mode,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic                                 rsp_found,
   input wire logic [ddet_pkg::MASK_WIDTH-1:0]      rsp_mask,
   input wire logic [ddet_pkg::COUNT_OUT_WIDTH-1:0] rsp_count
);
   import ddet_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mask)
                                 && $stable(rsp_count) && $stable(rsp_found))
      else $error("response changed while stalled");

   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_RUN |=> !req_ready)
      else $error("ready stayed high after a run request");

   a_mask_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mask != '0 |-> rsp_found)
      else $error("deadlocked mask set without deadlock_found");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_mask == '0 && rsp_count == '0)
      else $error("deadlock-free response carries a mask or count");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind deadlock_detector ddet_checker u_ddet_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_mode  (req_ch.mode),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_found (rsp_ch.deadlock_found),
   .rsp_mask  (rsp_ch.deadlocked_mask),
   .rsp_count (rsp_ch.deadlocked_count)
);

`default_nettype wire
